>>> sv/tgc_pkg.sv
// Shared types and constants for the touch gesture classifier.
// No dependencies; every other file refers to this package by scoped names.
package tgc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX_MS     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MIN_MS    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_MIN_DIST = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWIPE_MAX_MS   = 4'd3;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [15:0] TAP_MAX_MS_RST     = 16'd200;
    localparam logic [15:0] HOLD_MIN_MS_RST    = 16'd800;
    localparam logic [11:0] SWIPE_MIN_DIST_RST = 12'd30;
    localparam logic [15:0] SWIPE_MAX_MS_RST   = 16'd500;

    // Screen mapping: y uses 4/3 of the offset; 1/3 by reciprocal 21846/2^16,
    // exact for the magnitudes seen here (at most 15420).
    localparam int unsigned SCREEN_H   = 240;
    localparam int unsigned RECIP3     = 21846;
    localparam int unsigned RECIP3_SH  = 16;

    // Tap/hold movement limit is 10 screen units, compared squared
    localparam int unsigned TAP_DIST_SQ = 100;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        GEST_NONE        = 3'd0,
        GEST_TAP         = 3'd1,
        GEST_HOLD        = 3'd2,
        GEST_SWIPE_LEFT  = 3'd3,
        GEST_SWIPE_RIGHT = 3'd4,
        GEST_SWIPE_UP    = 3'd5,
        GEST_SWIPE_DOWN  = 3'd6
    } t_gesture;

    // One poll after the state update, front to back
    typedef struct packed {
        logic               active;
        logic [11:0]        x;
        logic signed [13:0] y;
        logic               lift;
        logic signed [12:0] dx;
        logic signed [13:0] dy;
        logic [31:0]        dur;
    } t_rec;

    // Thresholds handed to the back end
    typedef struct packed {
        logic [15:0] tap_max;
        logic [15:0] hold_min;
        logic [15:0] swipe_max;
        logic [23:0] smin_sq;
    } t_thresh;

    // Intermediate stage of the back end
    typedef struct packed {
        logic               active;
        logic [11:0]        x;
        logic signed [13:0] y;
        logic               lift;
        logic [23:0]        sqx;
        logic [25:0]        sqy;
        logic               x_dom;
        logic               dx_pos;
        logic               dy_pos;
        logic               tap_t;
        logic               hold_t;
        logic               swp_t;
    } t_mid;

    typedef struct packed {
        logic               active;
        logic [11:0]        x;
        logic signed [13:0] y;
        t_gesture           gesture;
    } t_result;

endpackage

>>> sv/tgc_front.sv
// Front end: coordinate mapping stage, then touch state tracking.
// Emits one tgc_pkg::t_rec per poll into the queue. Depends on tgc_pkg.
module tgc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_touch,
    input  logic [11:0]   i_raw_x,
    input  logic [11:0]   i_raw_y,
    input  logic [31:0]   i_now,
    input  logic          i_q_full,
    output logic          o_push,
    output tgc_pkg::t_rec o_rec
);

    logic [13:0]        w_x3;
    logic [11:0]        w_sx;
    logic signed [12:0] w_v;
    logic signed [12:0] w_neg_v;
    logic [11:0]        w_av;
    logic [28:0]        w_prod;
    logic [12:0]        w_q;
    logic signed [13:0] w_qs;
    logic signed [13:0] w_sy;
    logic               w_accept;
    logic signed [14:0] w_dy_full;

    logic               r_s1_valid;
    logic               r_s1_touch;
    logic [11:0]        r_s1_sx;
    logic signed [13:0] r_s1_sy;
    logic [31:0]        r_s1_now;

    logic               r_active;
    logic [11:0]        r_start_x;
    logic signed [13:0] r_start_y;
    logic [11:0]        r_recent_x;
    logic signed [13:0] r_recent_y;
    logic [31:0]        r_start_time;

    // x = raw*3/4
    assign w_x3 = {2'b00, i_raw_x} + {1'b0, i_raw_x, 1'b0};
    assign w_sx = w_x3[13:2];

    // y = trunc((240 - raw)*4/3), divided on the magnitude, sign put back
    assign w_v     = 13'(tgc_pkg::SCREEN_H) - $signed({1'b0, i_raw_y});
    assign w_neg_v = -w_v;
    assign w_av    = w_v[12] ? w_neg_v[11:0] : w_v[11:0];
    assign w_prod  = 29'({w_av, 2'b00}) * 29'(tgc_pkg::RECIP3);
    assign w_q     = w_prod[28:tgc_pkg::RECIP3_SH];
    assign w_qs    = $signed({1'b0, w_q});
    assign w_sy    = w_v[12] ? -w_qs : w_qs;

    assign o_push   = r_s1_valid && !i_q_full;
    assign o_ready  = i_rst_n && (!r_s1_valid || !i_q_full);
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (o_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_touch <= i_touch;
            r_s1_sx    <= w_sx;
            r_s1_sy    <= w_sy;
            r_s1_now   <= i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_start_x    <= '0;
            r_start_y    <= '0;
            r_recent_x   <= '0;
            r_recent_y   <= '0;
            r_start_time <= '0;
        end else if (o_push) begin
            if (r_s1_touch) begin
                if (!r_active) begin
                    r_active     <= 1'b1;
                    r_start_x    <= r_s1_sx;
                    r_start_y    <= r_s1_sy;
                    r_start_time <= r_s1_now;
                end
                r_recent_x <= r_s1_sx;
                r_recent_y <= r_s1_sy;
            end else begin
                r_active <= 1'b0;
            end
        end
    end

    assign w_dy_full = 15'(r_recent_y) - 15'(r_start_y);

    always_comb begin
        o_rec.active = r_s1_touch;
        o_rec.x      = r_s1_touch ? r_s1_sx : r_recent_x;
        o_rec.y      = r_s1_touch ? r_s1_sy : r_recent_y;
        o_rec.lift   = !r_s1_touch && r_active;
        o_rec.dx     = $signed({1'b0, r_recent_x}) - $signed({1'b0, r_start_x});
        o_rec.dy     = w_dy_full[13:0];
        o_rec.dur    = r_s1_now - r_start_time;   // wraps modulo 2^32
    end

endmodule

>>> sv/tgc_fifo.sv
// Small register queue carrying tgc_pkg::t_rec from front to back.
// Depth is a parameter (at least 2). Depends on tgc_pkg.
module tgc_fifo #(
    parameter int DEPTH = tgc_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tgc_pkg::t_rec i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tgc_pkg::t_rec o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    tgc_pkg::t_rec r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> sv/tgc_back.sv
// Back end: squares of the displacement and duration compares, then
// gesture decision into the output register. Depends on tgc_pkg.
module tgc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    output logic             o_pop,
    input  tgc_pkg::t_rec    i_rec,
    input  tgc_pkg::t_thresh i_thr,
    output logic             o_valid,
    input  logic             i_ready,
    output tgc_pkg::t_result o_res
);

    logic signed [12:0] w_ndx;
    logic signed [13:0] w_ndy;
    logic [11:0]        w_ax;
    logic [12:0]        w_ay;
    logic               w_b1_adv;
    logic               w_b1_ready;
    logic [26:0]        w_sq;
    logic               w_near;
    logic               w_far;
    tgc_pkg::t_gesture  w_gest;

    logic               r_b1_valid;
    tgc_pkg::t_mid      r_b1;
    logic               r_out_valid;
    tgc_pkg::t_result   r_res;

    assign w_ndx = -i_rec.dx;
    assign w_ndy = -i_rec.dy;
    assign w_ax  = i_rec.dx[12] ? w_ndx[11:0] : i_rec.dx[11:0];
    assign w_ay  = i_rec.dy[13] ? w_ndy[12:0] : i_rec.dy[12:0];

    assign w_b1_adv   = r_b1_valid && (!r_out_valid || i_ready);
    assign w_b1_ready = !r_b1_valid || w_b1_adv;
    assign o_pop      = i_q_valid && w_b1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else if (o_pop) begin
            r_b1_valid <= 1'b1;
        end else if (w_b1_adv) begin
            r_b1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b1.active <= i_rec.active;
            r_b1.x      <= i_rec.x;
            r_b1.y      <= i_rec.y;
            r_b1.lift   <= i_rec.lift;
            r_b1.sqx    <= 24'(w_ax) * 24'(w_ax);
            r_b1.sqy    <= 26'(w_ay) * 26'(w_ay);
            r_b1.x_dom  <= {1'b0, w_ax} > w_ay;
            r_b1.dx_pos <= !i_rec.dx[12] && (i_rec.dx != '0);
            r_b1.dy_pos <= !i_rec.dy[13] && (i_rec.dy != '0);
            r_b1.tap_t  <= i_rec.dur < 32'(i_thr.tap_max);
            r_b1.hold_t <= i_rec.dur >= 32'(i_thr.hold_min);
            r_b1.swp_t  <= i_rec.dur < 32'(i_thr.swipe_max);
        end
    end

    assign w_sq   = 27'(r_b1.sqx) + 27'(r_b1.sqy);
    assign w_near = w_sq < 27'(tgc_pkg::TAP_DIST_SQ);
    assign w_far  = w_sq >= 27'(i_thr.smin_sq);

    // tap wins over hold, hold over swipe
    always_comb begin
        w_gest = tgc_pkg::GEST_NONE;
        if (r_b1.lift) begin
            if (w_near && r_b1.tap_t) begin
                w_gest = tgc_pkg::GEST_TAP;
            end else if (w_near && r_b1.hold_t) begin
                w_gest = tgc_pkg::GEST_HOLD;
            end else if (w_far && r_b1.swp_t) begin
                if (r_b1.x_dom) begin
                    w_gest = r_b1.dx_pos ? tgc_pkg::GEST_SWIPE_RIGHT
                                         : tgc_pkg::GEST_SWIPE_LEFT;
                end else begin
                    w_gest = r_b1.dy_pos ? tgc_pkg::GEST_SWIPE_DOWN
                                         : tgc_pkg::GEST_SWIPE_UP;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_b1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b1_adv) begin
            r_res.active  <= r_b1.active;
            r_res.x       <= r_b1.x;
            r_res.y       <= r_b1.y;
            r_res.gesture <= w_gest;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

endmodule

>>> sv/touch_gesture_classifier_top.sv
// Top level of the touch gesture classifier: config registers, front end,
// queue and back end. Depends on tgc_pkg, tgc_front, tgc_fifo, tgc_back.
//
//  channel | dir | handshake                       | payload
//  --------+-----+---------------------------------+---------------------------------------
//  s_axis  | in  | i_s_axis_tvalid/o_s_axis_tready | tdata raw_x,raw_y,now_ms; tuser touch
//  m_axis  | out | o_m_axis_tvalid/i_m_axis_tready | tdata screen_x,screen_y,gesture;
//          |     |                                 | tuser touch_active
//  cfg     | in  | i_cfg_valid/o_cfg_ready         | i_cfg_index, i_cfg_data
//
// One poll per cycle sustained while the output keeps accepting; a poll passes the mapping
// register (loaded at the transfer), the state update into the queue, the squaring stage
// and the decision into the output register. The multiply in the mapping stage and the
// displacement squares set the stage timing.
// Reset is synchronous: touch state cleared, thresholds to defaults; input and
// config ready are low while reset is held.
// A stalled output fills the back stages and the queue before input stalls.
module touch_gesture_classifier_top #(
    parameter int QUEUE_DEPTH = tgc_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [55:0]                    i_s_axis_tdata,  // raw_x[11:0], raw_y[23:12], now_ms[55:24]
    input  logic                           i_s_axis_tuser,  // touch_present
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [31:0]                    o_m_axis_tdata,  // screen_x[11:0], screen_y[25:12], gesture[28:26]
    output logic                           o_m_axis_tuser,  // touch_active
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tgc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tgc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [15:0] r_tap_max;
    logic [15:0] r_hold_min;
    logic [15:0] r_swipe_max;
    logic [23:0] r_smin_sq;

    tgc_pkg::t_thresh w_thr;
    tgc_pkg::t_rec    w_push_rec;
    tgc_pkg::t_rec    w_pop_rec;
    tgc_pkg::t_result w_res;
    logic             w_push;
    logic             w_q_full;
    logic             w_pop;
    logic             w_q_valid;

    assign o_cfg_ready = i_rst_n;

    // distance threshold is kept squared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_max   <= tgc_pkg::TAP_MAX_MS_RST;
            r_hold_min  <= tgc_pkg::HOLD_MIN_MS_RST;
            r_swipe_max <= tgc_pkg::SWIPE_MAX_MS_RST;
            r_smin_sq   <= 24'(tgc_pkg::SWIPE_MIN_DIST_RST) * 24'(tgc_pkg::SWIPE_MIN_DIST_RST);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tgc_pkg::CFG_TAP_MAX_MS:     r_tap_max   <= i_cfg_data;
                tgc_pkg::CFG_HOLD_MIN_MS:    r_hold_min  <= i_cfg_data;
                tgc_pkg::CFG_SWIPE_MIN_DIST: begin
                    r_smin_sq <= 24'(i_cfg_data[11:0]) * 24'(i_cfg_data[11:0]);
                end
                tgc_pkg::CFG_SWIPE_MAX_MS:   r_swipe_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_thr.tap_max   = r_tap_max;
        w_thr.hold_min  = r_hold_min;
        w_thr.swipe_max = r_swipe_max;
        w_thr.smin_sq   = r_smin_sq;
    end

    tgc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_touch (i_s_axis_tuser),
        .i_raw_x (i_s_axis_tdata[11:0]),
        .i_raw_y (i_s_axis_tdata[23:12]),
        .i_now   (i_s_axis_tdata[55:24]),
        .i_q_full(w_q_full),
        .o_push  (w_push),
        .o_rec   (w_push_rec)
    );

    tgc_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data (w_push_rec),
        .o_full (w_q_full),
        .i_pop  (w_pop),
        .o_valid(w_q_valid),
        .o_data (w_pop_rec)
    );

    tgc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(w_q_valid),
        .o_pop    (w_pop),
        .i_rec    (w_pop_rec),
        .i_thr    (w_thr),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_res    (w_res)
    );

    assign o_m_axis_tuser = w_res.active;
    assign o_m_axis_tdata = {3'b000, w_res.gesture, w_res.y, w_res.x};

    // A gesture only comes with the lift, so the finger is reported up
    a_gest_on_lift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_res.gesture != tgc_pkg::GEST_NONE) |-> !w_res.active)
        else $error("gesture reported while touch still active");

    // Durations are unsigned, so a zero limit rules out the gesture
    a_tap_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_res.gesture == tgc_pkg::GEST_TAP) |-> (r_tap_max != '0))
        else $error("tap reported with zero tap limit");

    a_swipe_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && ((w_res.gesture == tgc_pkg::GEST_SWIPE_LEFT) ||
                            (w_res.gesture == tgc_pkg::GEST_SWIPE_RIGHT) ||
                            (w_res.gesture == tgc_pkg::GEST_SWIPE_UP) ||
                            (w_res.gesture == tgc_pkg::GEST_SWIPE_DOWN))
        |-> (r_swipe_max != '0))
        else $error("swipe reported with zero swipe time limit");

endmodule

>>> tb/tb.sv
// Self-checking testbench for touch_gesture_classifier_top: directed polls, then random
// touch sessions under several threshold settings, checked against an in-bench tracker.
// Depends on tgc_pkg and the classifier RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SCR_W       = 320;
    localparam int          SCR_H       = 240;
    localparam int          TAP_RADIUS  = 10;
    localparam int          N_PHASES    = 8;
    localparam int          PHASE_POLLS = 235;
    localparam int          TAIL_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT = 300_000;
    localparam int          IDX_W       = tgc_pkg::CFG_IDX_W;

    // highest register index, not mapped to any register
    localparam logic [IDX_W-1:0] CFG_IDX_TOP = '1;

    typedef enum logic { ROW_POLL, ROW_CFG } t_row_kind;
    typedef enum logic [1:0] { RCV_OPEN, RCV_CHOPPY, RCV_BLOCKY } t_rcv_mode;

    typedef struct {
        t_row_kind        kind;
        logic             touch;
        logic [11:0]      rx;
        logic [11:0]      ry;
        logic [31:0]      now;
        logic [IDX_W-1:0] reg_idx;
        logic [15:0]      reg_val;
        logic             typed;
        tgc_pkg::t_result want;
    } t_dir_row;

    logic                           i_clk           = 1'b0;
    logic                           i_rst_n         = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    logic [55:0]                    i_s_axis_tdata  = '0;  // raw_x[11:0], raw_y[23:12], now_ms[55:24]
    logic                           i_s_axis_tuser  = 1'b0; // touch_present
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    logic [31:0]                    o_m_axis_tdata;  // screen_x[11:0], screen_y[25:12], gesture[28:26]
    logic                           o_m_axis_tuser;  // touch_active
    logic                           i_cfg_valid     = 1'b0;
    logic                           o_cfg_ready;
    logic [IDX_W-1:0]               i_cfg_index     = '0;
    logic [tgc_pkg::CFG_DATA_W-1:0] i_cfg_data      = '0;

    touch_gesture_classifier_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Tracker copy of the thresholds and touch state
    logic [15:0] thr_tap_max    = tgc_pkg::TAP_MAX_MS_RST;
    logic [15:0] thr_hold_min   = tgc_pkg::HOLD_MIN_MS_RST;
    logic [11:0] thr_swipe_dist = tgc_pkg::SWIPE_MIN_DIST_RST;
    logic [15:0] thr_swipe_max  = tgc_pkg::SWIPE_MAX_MS_RST;
    logic        trk_active     = 1'b0;
    int          trk_x0         = 0;
    int          trk_y0         = 0;
    int          trk_x          = 0;
    int          trk_y          = 0;
    logic [31:0] trk_t0         = '0;

    tgc_pkg::t_result screen_q[$];    // expected results, oldest first
    t_dir_row         dir_rows[$];
    int               n_err      = 0;
    int unsigned      cycles     = 0;
    int               polls_sent = 0;
    int               burst_left = 0;
    logic             gappy      = 1'b1;
    logic             drv_typed  = 1'b0;
    tgc_pkg::t_result drv_want   = '0;
    logic [31:0]      wall_ms    = '0;

    // Map one poll onto the touch state and classify on lift
    function automatic tgc_pkg::t_result track_poll(logic touch, int rx, int ry,
                                                    logic [31:0] now);
        int               dx;
        int               dy;
        longint           ax;
        longint           ay;
        longint           sq;
        logic [31:0]      dur;
        tgc_pkg::t_result r;
        r.gesture = tgc_pkg::GEST_NONE;
        if (touch) begin
            trk_x = (rx * SCR_H) / SCR_W;
            trk_y = ((SCR_H - ry) * SCR_W) / SCR_H;  // signed divide truncates toward zero
            if (!trk_active) begin
                trk_active = 1'b1;
                trk_x0     = trk_x;
                trk_y0     = trk_y;
                trk_t0     = now;
            end
        end else if (trk_active) begin
            trk_active = 1'b0;
            dur = now - trk_t0;  // wraps modulo 2^32
            dx  = trk_x - trk_x0;
            dy  = trk_y - trk_y0;
            ax  = (dx < 0) ? -dx : dx;
            ay  = (dy < 0) ? -dy : dy;
            sq  = ax * ax + ay * ay;
            if (sq < TAP_RADIUS * TAP_RADIUS && dur < thr_tap_max) begin
                r.gesture = tgc_pkg::GEST_TAP;
            end else if (sq < TAP_RADIUS * TAP_RADIUS && dur >= thr_hold_min) begin
                r.gesture = tgc_pkg::GEST_HOLD;
            end else if (sq >= longint'(thr_swipe_dist) * longint'(thr_swipe_dist)
                         && dur < thr_swipe_max) begin
                if (ax > ay) begin
                    if (dx > 0) r.gesture = tgc_pkg::GEST_SWIPE_RIGHT;
                    else        r.gesture = tgc_pkg::GEST_SWIPE_LEFT;
                end else begin
                    if (dy > 0) r.gesture = tgc_pkg::GEST_SWIPE_DOWN;
                    else        r.gesture = tgc_pkg::GEST_SWIPE_UP;
                end
            end
        end
        r.active = trk_active;
        r.x      = trk_x[11:0];
        r.y      = trk_y[13:0];
        return r;
    endfunction

    // Directed table entries
    function automatic void poll_row(logic touch, logic [11:0] rx, logic [11:0] ry,
                                     logic [31:0] now);
        t_dir_row row;
        row         = '{kind: ROW_POLL, default: '0};
        row.touch   = touch;
        row.rx      = rx;
        row.ry      = ry;
        row.now     = now;
        dir_rows.push_back(row);
    endfunction

    function automatic void poll_row_want(logic touch, logic [11:0] rx, logic [11:0] ry,
                                          logic [31:0] now, logic act, logic [11:0] x,
                                          logic signed [13:0] y, tgc_pkg::t_gesture g);
        t_dir_row row;
        row              = '{kind: ROW_POLL, default: '0};
        row.touch        = touch;
        row.rx           = rx;
        row.ry           = ry;
        row.now          = now;
        row.typed        = 1'b1;
        row.want.active  = act;
        row.want.x       = x;
        row.want.y       = y;
        row.want.gesture = g;
        dir_rows.push_back(row);
    endfunction

    function automatic void cfg_row(logic [IDX_W-1:0] idx, logic [15:0] val);
        t_dir_row row;
        row         = '{kind: ROW_CFG, default: '0};
        row.reg_idx = idx;
        row.reg_val = val;
        dir_rows.push_back(row);
    endfunction

    // One poll transfer; between bursts of random length the sender may idle when gappy is set
    task automatic send_poll(logic touch, logic [11:0] rx, logic [11:0] ry, logic [31:0] now,
                             logic typed, tgc_pkg::t_result want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = gappy ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {now, ry, rx};
        i_s_axis_tuser  <= touch;
        drv_typed        = typed;
        drv_want         = want;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        polls_sent++;
    endtask

    // Stop sending and wait until every expected result has come back
    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (screen_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [IDX_W-1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // A well-formed touch: land, move over a few polls, lift after a chosen duration
    task automatic touch_session();
        int          n;
        int          x0;
        int          y0;
        int          x1;
        int          y1;
        logic [31:0] dur;
        logic [31:0] t0;
        // some durations cluster around the thresholds to hit both sides of each compare; the rest are random
        case ($urandom_range(0, 6))
            0:       dur = 32'(thr_tap_max) + 32'($urandom_range(0, 4)) - 32'd2;
            1:       dur = 32'(thr_hold_min) + 32'($urandom_range(0, 4)) - 32'd2;
            2:       dur = 32'(thr_swipe_max) + 32'($urandom_range(0, 4)) - 32'd2;
            3:       dur = $urandom_range(0, 300);
            4:       dur = $urandom_range(0, 2000);
            5:       dur = $urandom;
            default: dur = $urandom_range(0, 900);
        endcase
        x0 = $urandom_range(0, 4095);
        y0 = $urandom_range(0, 4095);
        x1 = x0;
        y1 = y0;
        case ($urandom_range(0, 4))
            0: ;  // finger stays put
            1: begin
                x1 = x0 + $urandom_range(0, 16) - 8;
                y1 = y0 + $urandom_range(0, 16) - 8;
                if (x1 < 0)    x1 = 0;
                if (x1 > 4095) x1 = 4095;
                if (y1 < 0)    y1 = 0;
                if (y1 > 4095) y1 = 4095;
            end
            2: x1 = $urandom_range(0, 4095);
            3: y1 = $urandom_range(0, 4095);
            default: begin
                x1 = $urandom_range(0, 4095);
                y1 = $urandom_range(0, 4095);
            end
        endcase
        n  = $urandom_range(1, 6);
        t0 = wall_ms;
        for (int k = 0; k < n; k++) begin
            send_poll(1'b1, 12'(x0 + (x1 - x0) * k / ((n > 1) ? n - 1 : 1)),
                      12'(y0 + (y1 - y0) * k / ((n > 1) ? n - 1 : 1)),
                      t0 + 32'((longint'(dur) * k) / n), 1'b0, '0);
        end
        send_poll(1'b0, 12'($urandom), 12'($urandom), t0 + dur, 1'b0, '0);
        wall_ms = t0 + dur + 32'($urandom_range(1, 3000));
        case ($urandom_range(0, 15))
            0:       wall_ms = $urandom;
            1:       wall_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 1000));
            default: ;
        endcase
    endtask

    // Receiver: open, choppy or long stalls, with the mode picked anew at random
    t_rcv_mode rcv_mode   = RCV_OPEN;
    int        rcv_cyc    = 0;
    int        stall_left = 0;

    always @(negedge i_clk) begin
        rcv_cyc++;
        if (rcv_cyc % 512 == 0) rcv_mode = t_rcv_mode'($urandom_range(0, 2));
        if (stall_left != 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_axis_tready <= 1'b1;
            case (rcv_mode)
                RCV_CHOPPY: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
                RCV_BLOCKY: if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(4, 12);
                default: ;
            endcase
        end
    end

    // Track config and poll transfers, compare result transfers
    always @(posedge i_clk) begin : monitor
        tgc_pkg::t_result r;
        tgc_pkg::t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    tgc_pkg::CFG_TAP_MAX_MS:     thr_tap_max    = i_cfg_data;
                    tgc_pkg::CFG_HOLD_MIN_MS:    thr_hold_min   = i_cfg_data;
                    tgc_pkg::CFG_SWIPE_MIN_DIST: thr_swipe_dist = i_cfg_data[11:0];
                    tgc_pkg::CFG_SWIPE_MAX_MS:   thr_swipe_max  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                r = track_poll(i_s_axis_tuser, int'(i_s_axis_tdata[11:0]),
                               int'(i_s_axis_tdata[23:12]), i_s_axis_tdata[55:24]);
                screen_q.push_back(drv_typed ? drv_want : r);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (screen_q.size() == 0) begin
                    $error("result transfer with nothing expected: tdata %h", o_m_axis_tdata);
                    n_err++;
                end else begin
                    want = screen_q.pop_front();
                    if (o_m_axis_tuser !== want.active) begin
                        $error("touch_active: expected %0d, got %0d", want.active,
                               o_m_axis_tuser);
                        n_err++;
                    end
                    if (o_m_axis_tdata[11:0] !== want.x) begin
                        $error("screen_x: expected %0d, got %0d", want.x,
                               o_m_axis_tdata[11:0]);
                        n_err++;
                    end
                    if (o_m_axis_tdata[25:12] !== want.y) begin
                        $error("screen_y: expected %0d, got %0d", want.y,
                               $signed(o_m_axis_tdata[25:12]));
                        n_err++;
                    end
                    if (o_m_axis_tdata[28:26] !== want.gesture) begin
                        $error("gesture: expected %0d, got %0d", want.gesture,
                               o_m_axis_tdata[28:26]);
                        n_err++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** touch_gesture_classifier_top: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        logic [15:0] th_tap;
        logic [15:0] th_hold;
        logic [15:0] th_dist;
        logic [15:0] th_swipe;
        int          target;

        // lift while idle before any touch: nothing changes, coordinates read zero
        poll_row_want(1'b0, 12'd4095, 12'd4095, 32'd0, 1'b0, 12'd0, 14'sd0,
                      tgc_pkg::GEST_NONE);
        // raw corners map to the screen extremes
        poll_row_want(1'b1, 12'd0, 12'd0, 32'd1000, 1'b1, 12'd0, 14'sd320,
                      tgc_pkg::GEST_NONE);
        poll_row_want(1'b0, 12'd0, 12'd0, 32'd1050, 1'b0, 12'd0, 14'sd320,
                      tgc_pkg::GEST_TAP);
        poll_row_want(1'b1, 12'd4095, 12'd4095, 32'd2000, 1'b1, 12'd3071, -14'sd5140,
                      tgc_pkg::GEST_NONE);
        poll_row_want(1'b0, 12'd0, 12'd0, 32'd3000, 1'b0, 12'd3071, -14'sd5140,
                      tgc_pkg::GEST_HOLD);
        // swipe right across the timestamp wrap
        poll_row_want(1'b1, 12'd320, 12'd240, 32'hFFFF_FFF0, 1'b1, 12'd240, 14'sd0,
                      tgc_pkg::GEST_NONE);
        poll_row_want(1'b1, 12'd360, 12'd240, 32'hFFFF_FFF8, 1'b1, 12'd270, 14'sd0,
                      tgc_pkg::GEST_NONE);
        poll_row_want(1'b0, 12'd0, 12'd0, 32'h0000_0010, 1'b0, 12'd270, 14'sd0,
                      tgc_pkg::GEST_SWIPE_RIGHT);
        // swipe left
        poll_row(1'b1, 12'd400, 12'd240, 32'd5000);
        poll_row(1'b1, 12'd0, 12'd240, 32'd5100);
        poll_row_want(1'b0, 12'd7, 12'd9, 32'd5200, 1'b0, 12'd0, 14'sd0,
                      tgc_pkg::GEST_SWIPE_LEFT);
        // swipe up; negative y truncates toward zero
        poll_row(1'b1, 12'd0, 12'd240, 32'd6000);
        poll_row(1'b1, 12'd0, 12'd301, 32'd6050);
        poll_row_want(1'b0, 12'd0, 12'd0, 32'd6100, 1'b0, 12'd0, -14'sd81,
                      tgc_pkg::GEST_SWIPE_UP);
        // swipe down
        poll_row(1'b1, 12'd0, 12'd240, 32'd7000);
        poll_row(1'b1, 12'd0, 12'd0, 32'd7010);
        poll_row_want(1'b0, 12'd0, 12'd0, 32'd7020, 1'b0, 12'd0, 14'sd320,
                      tgc_pkg::GEST_SWIPE_DOWN);
        // too long for a tap, too short for a hold, no movement: nothing
        poll_row(1'b1, 12'd100, 12'd100, 32'd8000);
        poll_row_want(1'b0, 12'd0, 12'd0, 32'd8400, 1'b0, 12'd75, 14'sd186,
                      tgc_pkg::GEST_NONE);
        // zero swipe distance: a still touch becomes a swipe up; upper distance bits dropped
        cfg_row(tgc_pkg::CFG_TAP_MAX_MS,     16'h0000);
        cfg_row(tgc_pkg::CFG_HOLD_MIN_MS,    16'hFFFF);
        cfg_row(tgc_pkg::CFG_SWIPE_MIN_DIST, 16'hF000);
        cfg_row(tgc_pkg::CFG_SWIPE_MAX_MS,   16'hFFFF);
        cfg_row(CFG_IDX_TOP,                 16'h0001);  // unmapped index, no effect
        poll_row(1'b1, 12'd100, 12'd100, 32'd9000);
        poll_row_want(1'b0, 12'd0, 12'd0, 32'd39000, 1'b0, 12'd75, 14'sd186,
                      tgc_pkg::GEST_SWIPE_UP);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain();
                cfg_write(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                send_poll(dir_rows[i].touch, dir_rows[i].rx, dir_rows[i].ry, dir_rows[i].now,
                          dir_rows[i].typed, dir_rows[i].want);
            end
        end

        wall_ms = 32'd50_000;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    th_tap   = tgc_pkg::TAP_MAX_MS_RST;
                    th_hold  = tgc_pkg::HOLD_MIN_MS_RST;
                    th_dist  = 16'(tgc_pkg::SWIPE_MIN_DIST_RST);
                    th_swipe = tgc_pkg::SWIPE_MAX_MS_RST;
                end
                1: begin
                    th_tap   = '0;
                    th_hold  = '0;
                    th_dist  = '0;
                    th_swipe = '0;
                end
                2: begin
                    th_tap   = '1;
                    th_hold  = '1;
                    th_dist  = '1;
                    th_swipe = '1;
                end
                default: begin
                    th_tap   = $urandom_range(20, 400);
                    th_hold  = $urandom_range(150, 1500);
                    th_dist  = {4'($urandom), 12'($urandom_range(0, 120))};
                    th_swipe = $urandom_range(80, 1200);
                    if ($urandom_range(0, 3) == 0) begin
                        th_tap   = $urandom;
                        th_hold  = $urandom;
                        th_dist  = $urandom;
                        th_swipe = $urandom;
                    end
                end
            endcase
            drain();
            cfg_write(tgc_pkg::CFG_TAP_MAX_MS,     th_tap);
            cfg_write(tgc_pkg::CFG_HOLD_MIN_MS,    th_hold);
            cfg_write(tgc_pkg::CFG_SWIPE_MIN_DIST, th_dist);
            cfg_write(tgc_pkg::CFG_SWIPE_MAX_MS,   th_swipe);
            cfg_write(tgc_pkg::CFG_SWIPE_MAX_MS + IDX_W'($urandom_range(1, 12)),
                      16'($urandom));
            gappy  = ($urandom_range(0, 2) != 0);
            target = polls_sent + PHASE_POLLS;
            while (polls_sent < target) begin
                // mostly complete touches; some stray polls break the sequences
                if ($urandom_range(0, 7) == 0) begin
                    send_poll(1'($urandom), 12'($urandom), 12'($urandom), wall_ms, 1'b0, '0);
                    wall_ms = wall_ms + 32'($urandom_range(0, 500));
                end else begin
                    touch_session();
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_err == 0 && screen_q.size() == 0) begin
            $display("** touch_gesture_classifier_top: PASSED **");
        end else begin
            $display("** touch_gesture_classifier_top: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/tgc_pkg.sv
sv/tgc_front.sv
sv/tgc_fifo.sv
sv/tgc_back.sv
sv/touch_gesture_classifier_top.sv
tb/tb.sv
